// File: rtl/core/irpm_pkg.sv
// Package: shared types and constants of the IR pulse run-length merger.
`timescale 1ns / 1ps
`default_nettype none

package irpm_pkg;

  // Samples packed into one input word, byte 0 first
  localparam int SAMPLES_PER_WORD = 4;
  localparam int STEP_W           = $clog2(SAMPLES_PER_WORD);
  localparam int DUR_W            = 7;
  localparam int LIMIT_W          = 9;
  localparam int OUT_WIDTH_W      = 16;
  localparam int WORD_W           = 32;

  localparam logic [LIMIT_W-1:0]     IDLE_LIMIT_RESET = 9'd64;
  localparam logic [OUT_WIDTH_W-1:0] OUT_WIDTH_MAX    = 16'hFFFF;

  // Depth of the word queue at the input and of the result queue at the output
  localparam int WORD_Q_DEPTH = 2;
  localparam int OUT_Q_DEPTH  = 4;

  // One unpacked sample: pin level and duration
  typedef struct packed {
    logic             level;
    logic [DUR_W-1:0] dur;
  } sample_t;

  typedef sample_t [SAMPLES_PER_WORD-1:0] word_samples_t;

  // One finished pulse
  typedef struct packed {
    logic                   level;
    logic [OUT_WIDTH_W-1:0] width;
    logic                   last;
  } pulse_t;

endpackage

`default_nettype wire

// File: rtl/core/irpm_front.sv
// Front end: accepts sample words, unpacks them and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none

module irpm_front (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          push,
  output logic                         full,
  input  wire  [irpm_pkg::WORD_W-1:0]  sample_word,
  output logic                         word_valid,
  output irpm_pkg::word_samples_t      word_samples,
  input  wire                          word_pop
);
  import irpm_pkg::*;

  localparam int PTR_W = $clog2(WORD_Q_DEPTH);
  localparam int CNT_W = $clog2(WORD_Q_DEPTH + 1);

  word_samples_t            word_q [WORD_Q_DEPTH];
  logic [PTR_W-1:0]         wr_ptr;
  logic [PTR_W-1:0]         rd_ptr;
  logic [CNT_W-1:0]         count;
  word_samples_t            unpacked;
  logic                     do_push;
  logic                     do_pop;

  // Split the word into level and duration per byte
  always_comb begin
    for (int i = 0; i < SAMPLES_PER_WORD; i++) begin
      unpacked[i].level = sample_word[8*i+7];
      unpacked[i].dur   = sample_word[8*i +: DUR_W];
    end
  end

  assign full         = (count == CNT_W'(WORD_Q_DEPTH));
  assign word_valid   = (count != '0);
  assign word_samples = word_q[rd_ptr];
  assign do_push      = push && !full;
  assign do_pop       = word_pop && word_valid;

  // Store incoming items
  always_ff @(posedge clk) begin
    if (do_push) begin
      word_q[wr_ptr] <= unpacked;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/irpm_back.sv
// Back end: merges samples into pulses, one sample per cycle unless stalled, and marks the last pulse of each word.
`timescale 1ns / 1ps
`default_nettype none

module irpm_back #(
  parameter int WIDTH_BITS = 16
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire  [irpm_pkg::LIMIT_W-1:0]   idle_high_limit,
  input  wire                            word_valid,
  input  irpm_pkg::word_samples_t        word_samples,
  output logic                           word_pop,
  input  wire                            out_full,
  output logic                           out_push,
  output irpm_pkg::pulse_t               out_item
);
  import irpm_pkg::*;

  // Running state
  logic [STEP_W-1:0]     step;
  logic [WIDTH_BITS-1:0] run;
  logic                  cur;
  logic                  pend_v;
  pulse_t                pend;
  logic                  flush;

  sample_t               smp;
  logic                  last_step;
  logic                  boundary;
  logic                  idle;
  logic                  emit;
  logic [31:0]           run_ext;
  pulse_t                new_pulse;
  logic [WIDTH_BITS-1:0] base;
  logic [WIDTH_BITS:0]   sum;
  logic [WIDTH_BITS-1:0] run_next;
  logic                  need_push;
  logic                  go;
  logic                  flush_go;

  assign smp       = word_samples[step];
  assign last_step = (step == STEP_W'(SAMPLES_PER_WORD - 1));

  // Classify the level change against the running pulse
  assign boundary = (run != '0) && (smp.level != cur);
  assign idle     = cur && (run > WIDTH_BITS'(idle_high_limit));
  assign emit     = boundary && !idle;

  // Clamp the running width to the output field
  assign run_ext         = 32'(run);
  assign new_pulse.level = cur;
  assign new_pulse.width = (run_ext > 32'(OUT_WIDTH_MAX)) ? OUT_WIDTH_MAX
                                                          : run_ext[OUT_WIDTH_W-1:0];
  assign new_pulse.last  = 1'b0;

  // Saturating accumulate of the duration
  assign base     = boundary ? '0 : run;
  assign sum      = {1'b0, base} + (WIDTH_BITS+1)'(smp.dur);
  assign run_next = sum[WIDTH_BITS] ? '1 : sum[WIDTH_BITS-1:0];

  // Pick the result to push this cycle
  always_comb begin
    need_push = 1'b0;
    out_item  = pend;
    if (flush) begin
      need_push     = 1'b1;
      out_item      = pend;
      out_item.last = 1'b1;
    end else if (emit && pend_v) begin
      need_push     = 1'b1;
      out_item      = pend;
      out_item.last = 1'b0;
    end else if (last_step && pend_v) begin
      need_push     = 1'b1;
      out_item      = pend;
      out_item.last = 1'b1;
    end else if (last_step && emit) begin
      need_push     = 1'b1;
      out_item      = new_pulse;
      out_item.last = 1'b1;
    end
  end

  assign flush_go = flush && !out_full;
  assign go       = word_valid && !flush && (!need_push || !out_full);
  assign out_push = need_push && (flush_go || go);
  assign word_pop = go && last_step;

  // Advance the sample sequencer and the pending pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      step   <= '0;
      run    <= '0;
      cur    <= 1'b0;
      pend_v <= 1'b0;
      flush  <= 1'b0;
    end else if (flush_go) begin
      flush  <= 1'b0;
      pend_v <= 1'b0;
    end else if (go) begin
      step <= step + STEP_W'(1);
      run  <= run_next;
      cur  <= smp.level;
      if (emit) begin
        if (pend_v) begin
          pend   <= new_pulse;
          pend_v <= 1'b1;
          flush  <= last_step;
        end else if (last_step) begin
          pend_v <= 1'b0;
        end else begin
          pend   <= new_pulse;
          pend_v <= 1'b1;
        end
      end else if (last_step) begin
        pend_v <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/irpm_out_q.sv
// Result queue: holds finished pulses until they are taken.
`timescale 1ns / 1ps
`default_nettype none

module irpm_out_q (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_push,
  input  irpm_pkg::pulse_t  in_item,
  output logic              in_full,
  input  wire               pop,
  output logic              empty,
  output irpm_pkg::pulse_t  head
);
  import irpm_pkg::*;

  localparam int PTR_W = $clog2(OUT_Q_DEPTH);
  localparam int CNT_W = $clog2(OUT_Q_DEPTH + 1);

  pulse_t           item_q [OUT_Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign in_full = (count == CNT_W'(OUT_Q_DEPTH));
  assign empty   = (count == '0);
  assign head    = item_q[rd_ptr];
  assign do_push = in_push && !in_full;
  assign do_pop  = pop && !empty;

  // Store pulses
  always_ff @(posedge clk) begin
    if (do_push) begin
      item_q[wr_ptr] <= in_item;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ir_pulse_run_length_merger_core.sv
// Top level of the IR pulse run-length merger: config register and the three stages.
//
//   channel   signals                                          direction
//   --------  -----------------------------------------------  ---------
//   words     push, full, sample_word                          in
//   pulses    empty, pop, pulse_level, pulse_width, last_of_run out
//   config    cfg_valid, cfg_ready, cfg_idle_high_limit        in
//
// The back end handles one sample per cycle while it is not stalled; a word whose last
// sample finishes a pulse while an earlier one still waits also passes through the flush state.
// A two-word queue at the input and a four-pulse queue at the output let both
// sides stall independently; the back end halts when the result queue is full, when no word waits, or during a flush.
// Reset (rst, synchronous) empties both queues, clears the running pulse and
// loads the idle limit with 64. cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module ir_pulse_run_length_merger_core #(
  parameter int WIDTH_BITS = 16
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               push,
  output logic                              full,
  input  wire  [irpm_pkg::WORD_W-1:0]       sample_word,
  output logic                              empty,
  input  wire                               pop,
  output logic                              pulse_level,
  output logic [irpm_pkg::OUT_WIDTH_W-1:0]  pulse_width,
  output logic                              last_of_run,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [irpm_pkg::LIMIT_W-1:0]      cfg_idle_high_limit
);
  import irpm_pkg::*;

  logic [LIMIT_W-1:0] idle_high_limit;
  logic               word_valid;
  word_samples_t      word_samples;
  logic               word_pop;
  logic               q_full;
  logic               q_push;
  pulse_t             q_item;
  pulse_t             head;

  // Hold the idle limit register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_high_limit <= IDLE_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      idle_high_limit <= cfg_idle_high_limit;
    end
  end

  irpm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .sample_word  (sample_word),
    .word_valid   (word_valid),
    .word_samples (word_samples),
    .word_pop     (word_pop)
  );

  irpm_back #(
    .WIDTH_BITS (WIDTH_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .idle_high_limit (idle_high_limit),
    .word_valid      (word_valid),
    .word_samples    (word_samples),
    .word_pop        (word_pop),
    .out_full        (q_full),
    .out_push        (q_push),
    .out_item        (q_item)
  );

  irpm_out_q u_out_q (
    .clk     (clk),
    .rst     (rst),
    .in_push (q_push),
    .in_item (q_item),
    .in_full (q_full),
    .pop     (pop),
    .empty   (empty),
    .head    (head)
  );

  // Drive the result fields from the queue head
  assign pulse_level = head.level;
  assign pulse_width = head.width;
  assign last_of_run = head.last;

endmodule

`default_nettype wire

// File: sim/tb.sv
// Testbench for the IR pulse run-length merger: directed and random words against a predictor.
`timescale 1ns / 1ps

module tb;
  import irpm_pkg::*;

  localparam int                     RUN_BITS    = 16;
  localparam logic [RUN_BITS-1:0]    RUN_MAX     = {RUN_BITS{1'b1}};
  localparam int                     SETTLE_CYC  = 24;
  localparam int                     RAND_WORDS  = 6;
  localparam int                     BURST_WORDS = 16;

  logic                   clk;
  logic                   rst;
  logic                   push;
  logic                   full;
  logic [WORD_W-1:0]      sample_word;
  logic                   empty;
  logic                   pop;
  logic                   pulse_level;
  logic [OUT_WIDTH_W-1:0] pulse_width;
  logic                   last_of_run;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [LIMIT_W-1:0]     cfg_idle_high_limit;

  // Predictor state: running pulse and the idle limit
  logic [RUN_BITS-1:0]    pend_width;
  logic                   pend_level;
  logic [LIMIT_W-1:0]     limit_shadow;
  logic                   gen_level;

  pulse_t                 pending_pulses[$];
  int                     send_idle_pct;
  int                     pop_idle_pct;
  int                     err_count;

  ir_pulse_run_length_merger_core #(
    .WIDTH_BITS(RUN_BITS)
  ) uut (
    .clk                 (clk),
    .rst                 (rst),
    .push                (push),
    .full                (full),
    .sample_word         (sample_word),
    .empty               (empty),
    .pop                 (pop),
    .pulse_level         (pulse_level),
    .pulse_width         (pulse_width),
    .last_of_run         (last_of_run),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_idle_high_limit (cfg_idle_high_limit)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Merge the four samples of one word and queue the pulses they finish
  task automatic merge_word(input logic [WORD_W-1:0] w);
    pulse_t              found[4];
    int                  n;
    int                  k;
    logic [7:0]          smp;
    logic [RUN_BITS:0]   sum;
    pulse_t              p;
    n = 0;
    for (k = 0; k < SAMPLES_PER_WORD; k++) begin
      smp = w[8*k +: 8];
      if (pend_width != '0 && smp[7] != pend_level) begin
        // drop a high pulse wider than the limit, but clear it all the same
        if (!(pend_level && pend_width > RUN_BITS'(limit_shadow))) begin
          p.level = pend_level;
          p.width = (pend_width > RUN_BITS'(OUT_WIDTH_MAX)) ? OUT_WIDTH_MAX
                                                           : OUT_WIDTH_W'(pend_width);
          p.last  = 1'b0;
          found[n] = p;
          n++;
        end
        pend_width = '0;
      end
      sum = {1'b0, pend_width} + (RUN_BITS+1)'(smp[6:0]);
      pend_width = (sum > {1'b0, RUN_MAX}) ? RUN_MAX : sum[RUN_BITS-1:0];
      pend_level = smp[7];
    end
    for (k = 0; k < n; k++) begin
      p = found[k];
      p.last = (k == n - 1);
      pending_pulses.push_back(p);
    end
  endtask

  // Offer one word, idling at random first; push stays high for a following word
  task automatic send_word(input logic [WORD_W-1:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push        <= 1'b1;
    sample_word <= w;
    do @(posedge clk); while (full);
    merge_word(w);
  endtask

  // Hold the sender until every pulse has come and the back end is quiet
  task automatic settle();
    push <= 1'b0;
    while (pending_pulses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    cfg_valid           <= 1'b1;
    cfg_idle_high_limit <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    limit_shadow  = v;
  endtask

  // Random word: mostly runs of random content, some pure noise
  function automatic logic [WORD_W-1:0] gen_word();
    logic [WORD_W-1:0] w;
    logic [6:0]        d;
    int                k;
    if ($urandom_range(9) < 2) return $urandom();
    for (k = 0; k < SAMPLES_PER_WORD; k++) begin
      if ($urandom_range(1) == 1) gen_level = ~gen_level;
      case ($urandom_range(3))
        0: d = 7'd0;
        1: d = 7'($urandom_range(15, 1));
        2: d = 7'($urandom_range(127));
        default: d = 7'h7F;
      endcase
      w[8*k +: 8] = {gen_level, d};
    end
    return w;
  endfunction

  // Check each popped pulse against the oldest prediction
  always @(posedge clk) begin
    pulse_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_pulses.size() == 0) begin
          $error("unexpected pulse: level %0d width %0d last %0d",
                 pulse_level, pulse_width, last_of_run);
          err_count++;
        end else begin
          want = pending_pulses.pop_front();
          if (pulse_level !== want.level) begin
            $error("pulse_level: expected %0d, actual %0d", want.level, pulse_level);
            err_count++;
          end
          if (pulse_width !== want.width) begin
            $error("pulse_width: expected %0d, actual %0d", want.width, pulse_width);
            err_count++;
          end
          if (last_of_run !== want.last) begin
            $error("last_of_run: expected %0d, actual %0d", want.last, last_of_run);
            err_count++;
          end
        end
      end
      pop <= ($urandom_range(99) >= pop_idle_pct);
    end
  end

  // Reset limit: extremes, the limit boundary, zero-width flips, four pulses per word
  task automatic test_reset_limit();
    send_word(32'h0000_0000);
    send_word(32'h8080_8080);
    send_word(32'h0000_00C0);
    send_word(32'h0000_00C1);
    send_word(32'h0300_8005);
    send_word(32'h0000_0005);
    send_word(32'h0A8A_0A8A);
    send_word(32'h8A0A_8A0A);
    send_word(32'h7F7F_7F7F);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);
    send_word(32'h0080_0080);
    send_word(32'h0000_0000);
    settle();
  endtask

  // Limit at both ends of its range
  task automatic test_limit_extremes();
    write_limit('0);
    send_word(32'h0081_0081);
    send_word(32'h0000_0081);
    send_word(32'h8000_0000);
    settle();
    write_limit('1);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0083);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0084);
    send_word(32'hFF7F_00FF);
    settle();
  endtask

  // A long low run that clips the running width at its maximum
  task automatic test_saturation();
    int i;
    write_limit(LIMIT_W'(64));
    for (i = 0; i < 130; i++) send_word(32'h7F7F_7F7F);
    send_word(32'h0000_8001);
    send_word(32'h0000_0002);
    send_word(32'h0000_8000);
    settle();
  endtask

  // Random words over several limit settings, one phase with no idling
  task automatic test_random_phases();
    int ph;
    int i;
    int n_words;
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_limit(LIMIT_W'($urandom_range(511)));
        1: write_limit(LIMIT_W'($urandom_range(100, 20)));
        2: write_limit('1);
        default: write_limit('0);
      endcase
      if (ph == 2) begin
        send_idle_pct = 0;
        pop_idle_pct  = 0;
        n_words       = BURST_WORDS;
      end else begin
        send_idle_pct = 37;
        pop_idle_pct  = 37;
        n_words       = RAND_WORDS;
      end
      for (i = 0; i < n_words; i++) send_word(gen_word());
      settle();
    end
    send_idle_pct = 37;
    pop_idle_pct  = 37;
  endtask

  initial begin
    clk                 = 1'b0;
    rst                 = 1'b1;
    push                = 1'b0;
    sample_word         = '0;
    cfg_valid           = 1'b0;
    cfg_idle_high_limit = '0;
    pend_width          = '0;
    pend_level          = 1'b0;
    limit_shadow        = IDLE_LIMIT_RESET;
    gen_level           = 1'b0;
    send_idle_pct       = 37;
    pop_idle_pct        = 37;
    err_count           = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_limit();
    test_limit_extremes();
    test_saturation();
    test_random_phases();
    settle();
    if (err_count == 0 && pending_pulses.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Give up on a hang
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
